// ===== rtl/thsp_pkg.sv =====
// Shared types and constants for the tar header stream parser.
package thsp_pkg;

   localparam int unsigned POS_W = 9;
   localparam int unsigned BIG_W = 37;

   // header byte offsets
   localparam logic [POS_W-1:0] POS_FIRST   = 9'd0;
   localparam logic [POS_W-1:0] POS_MODE    = 9'd100;
   localparam logic [POS_W-1:0] POS_UID     = 9'd108;
   localparam logic [POS_W-1:0] POS_GID     = 9'd116;
   localparam logic [POS_W-1:0] POS_SIZE    = 9'd124;
   localparam logic [POS_W-1:0] POS_MTIME   = 9'd136;
   localparam logic [POS_W-1:0] POS_NUM_END = 9'd148;
   localparam logic [POS_W-1:0] POS_TYPE    = 9'd156;
   localparam logic [POS_W-1:0] POS_PREFIX  = 9'd345;
   localparam logic [POS_W-1:0] POS_LAST    = 9'd511;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DIR   = 8'h35;
   localparam logic [7:0] CH_LINK  = 8'h32;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [1:0] CLS_HEADER  = 2'd0;
   localparam logic [1:0] CLS_CONTENT = 2'd1;
   localparam logic [1:0] CLS_PAD     = 2'd2;
   localparam logic [1:0] CLS_END     = 2'd3;

   localparam logic [1:0] KIND_FILE = 2'd0;
   localparam logic [1:0] KIND_DIR  = 2'd1;
   localparam logic [1:0] KIND_LINK = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_CONTENT = 2'd1,
      PH_PAD     = 2'd2,
      PH_END     = 2'd3
   } phase_type;

   // header summary handed from the field scanner to the sequencer
   typedef struct packed {
      logic             zero_blk;
      logic             drop;
      logic [1:0]       kind;
      logic [8:0]       perm;
      logic [15:0]      uid;
      logic [15:0]      gid;
      logic [BIG_W-1:0] size;
      logic [BIG_W-1:0] mtime;
   } entry_type;

   typedef struct packed {
      logic [1:0]       byte_class;
      logic [7:0]       byte_out;
      logic             entry_valid;
      logic [1:0]       entry_kind;
      logic [8:0]       perm_bits;
      logic [15:0]      owner_id;
      logic [15:0]      group_id;
      logic [BIG_W-1:0] entry_size;
      logic [BIG_W-1:0] mod_time;
      logic             archive_end;
   } rsp_type;

endpackage

// ===== rtl/thsp_stream_ifs.sv =====
// Valid/ready channel interfaces for the parser's byte input and result output.
interface thsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface thsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  byte_class;
   logic [7:0]  byte_out;
   logic        entry_valid;
   logic [1:0]  entry_kind;
   logic [8:0]  perm_bits;
   logic [15:0] owner_id;
   logic [15:0] group_id;
   logic [36:0] entry_size;
   logic [36:0] mod_time;
   logic        archive_end;

   modport source (output valid, output byte_class, output byte_out, output entry_valid,
                   output entry_kind, output perm_bits, output owner_id, output group_id,
                   output entry_size, output mod_time, output archive_end, input ready);
   modport sink   (input valid, input byte_class, input byte_out, input entry_valid,
                   input entry_kind, input perm_bits, input owner_id, input group_id,
                   input entry_size, input mod_time, input archive_end, output ready);
endinterface

// ===== rtl/tar_header_stream_parser_unit.sv =====
// Tar stream parser top level: input register, parse logic, result register.
//
// Usage: archive bytes enter on req_ch (valid/ready), one word per byte.
// Every accepted byte yields exactly one result word on rsp_ch, in order:
// the byte's class (header, content, padding, after end), the byte itself,
// and on the last byte of a 512-byte header the decoded entry (kind, mode
// bits, uid, gid, size, mtime) or the end-of-archive flag; an entry whose
// name and prefix are both empty gives no report. Each accepted byte is
// parsed from the input register into the result register.
// Throughput: one byte per cycle while rsp_ch is not stalled; the parser
// state and the header field accumulators update once per byte.
// Stall: when rsp_ch.ready is low the result register holds, the input
// register can take one more byte, then req_ch.ready drops until the result
// leaves. Reset (synchronous) empties both registers and returns the parser
// to the start of a header block.
module tar_header_stream_parser_unit (
   input  logic       clock,
   input  logic       reset,
   thsp_req_if.sink   req_ch,
   thsp_rsp_if.source rsp_ch
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff;
   thsp_pkg::rsp_type   rsp_ff, rsp_in;
   thsp_pkg::entry_type entry;
   logic                advance, hdr_step;
   logic [8:0]          pos;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.byte_in;
      end
   end

   thsp_hdr_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (hdr_step),
      .pos     (pos),
      .byte_in (in_byte_ff),
      .entry   (entry)
   );

   thsp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .byte_in  (in_byte_ff),
      .entry    (entry),
      .hdr_step (hdr_step),
      .pos      (pos),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.byte_class  = rsp_ff.byte_class;
   assign rsp_ch.byte_out    = rsp_ff.byte_out;
   assign rsp_ch.entry_valid = rsp_ff.entry_valid;
   assign rsp_ch.entry_kind  = rsp_ff.entry_kind;
   assign rsp_ch.perm_bits   = rsp_ff.perm_bits;
   assign rsp_ch.owner_id    = rsp_ff.owner_id;
   assign rsp_ch.group_id    = rsp_ff.group_id;
   assign rsp_ch.entry_size  = rsp_ff.entry_size;
   assign rsp_ch.mod_time    = rsp_ff.mod_time;
   assign rsp_ch.archive_end = rsp_ff.archive_end;

endmodule

// ===== rtl/thsp_hdr_scan.sv =====
// Header field scanner: name, octal fields, type flag and zero-block detection.
module thsp_hdr_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [8:0]          pos,
   input  logic [7:0]          byte_in,
   output thsp_pkg::entry_type entry
);

   logic [8:0]  perm_ff, perm_in;
   logic [15:0] uid_ff, uid_in, gid_ff, gid_in;
   logic [36:0] size_ff, size_in, time_ff, time_in;
   logic        digits_open_ff, digits_open_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  last_char_ff, last_char_in;
   logic        name_open_ff, name_open_in;
   logic        name_empty_ff, name_empty_in;
   logic        prefix_empty_ff, prefix_empty_in;
   logic        zero_blk_ff, zero_blk_in;

   logic        first, is_start, in_num, is_digit, digits_cur, take;
   logic [3:0]  digit;
   logic [8:0]  perm_base;
   logic [15:0] uid_base, gid_base;
   logic [36:0] size_base, time_base;
   logic        name_open_base;

   always_comb begin
      first    = (pos == thsp_pkg::POS_FIRST);
      is_start = (pos == thsp_pkg::POS_MODE) || (pos == thsp_pkg::POS_UID) ||
                 (pos == thsp_pkg::POS_GID) || (pos == thsp_pkg::POS_SIZE) ||
                 (pos == thsp_pkg::POS_MTIME);
      in_num   = (pos >= thsp_pkg::POS_MODE) && (pos < thsp_pkg::POS_NUM_END);
      is_digit = (byte_in >= thsp_pkg::CH_ZERO) && (byte_in <= thsp_pkg::CH_NINE);
      digit    = 4'(byte_in - thsp_pkg::CH_ZERO);
      digits_cur = is_start ? 1'b1 : digits_open_ff;
      take     = in_num && digits_cur && is_digit;

      // the first header byte starts a fresh entry
      perm_base      = first ? '0 : perm_ff;
      uid_base       = first ? '0 : uid_ff;
      gid_base       = first ? '0 : gid_ff;
      size_base      = first ? '0 : size_ff;
      time_base      = first ? '0 : time_ff;
      name_open_base = first ? 1'b1 : name_open_ff;

      perm_in = perm_base;
      uid_in  = uid_base;
      gid_in  = gid_base;
      size_in = size_base;
      time_in = time_base;
      if (take) begin
         if (pos < thsp_pkg::POS_UID) begin
            perm_in = {perm_base[5:0], 3'b000} | {5'b0, digit};
         end else if (pos < thsp_pkg::POS_GID) begin
            uid_in = {uid_base[12:0], 3'b000} | {12'b0, digit};
         end else if (pos < thsp_pkg::POS_SIZE) begin
            gid_in = {gid_base[12:0], 3'b000} | {12'b0, digit};
         end else if (pos < thsp_pkg::POS_MTIME) begin
            size_in = {size_base[33:0], 3'b000} | {33'b0, digit};
         end else begin
            time_in = {time_base[33:0], 3'b000} | {33'b0, digit};
         end
      end

      digits_open_in = digits_open_ff;
      if (in_num) begin
         digits_open_in = digits_cur && is_digit;
      end

      name_open_in  = name_open_base;
      name_empty_in = first ? 1'b1 : name_empty_ff;
      last_char_in  = first ? 8'h00 : last_char_ff;
      if ((pos < thsp_pkg::POS_MODE) && name_open_base) begin
         if (byte_in == 8'h00) begin
            name_open_in = 1'b0;
         end else begin
            last_char_in  = byte_in;
            name_empty_in = 1'b0;
         end
      end

      type_in         = (pos == thsp_pkg::POS_TYPE) ? byte_in : type_ff;
      prefix_empty_in = (pos == thsp_pkg::POS_PREFIX) ? (byte_in == 8'h00) : prefix_empty_ff;
      zero_blk_in     = (first ? 1'b1 : zero_blk_ff) && (byte_in == 8'h00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_ff         <= '0;
         uid_ff          <= '0;
         gid_ff          <= '0;
         size_ff         <= '0;
         time_ff         <= '0;
         digits_open_ff  <= 1'b1;
         type_ff         <= '0;
         last_char_ff    <= '0;
         name_open_ff    <= 1'b1;
         name_empty_ff   <= 1'b1;
         prefix_empty_ff <= 1'b1;
         zero_blk_ff     <= 1'b1;
      end else if (step) begin
         perm_ff         <= perm_in;
         uid_ff          <= uid_in;
         gid_ff          <= gid_in;
         size_ff         <= size_in;
         time_ff         <= time_in;
         digits_open_ff  <= digits_open_in;
         type_ff         <= type_in;
         last_char_ff    <= last_char_in;
         name_open_ff    <= name_open_in;
         name_empty_ff   <= name_empty_in;
         prefix_empty_ff <= prefix_empty_in;
         zero_blk_ff     <= zero_blk_in;
      end
   end

   // summary is only consumed on the last header byte, where only the
   // zero-block flag still depends on the current byte
   always_comb begin
      entry.zero_blk = zero_blk_in;
      entry.drop     = name_empty_ff && prefix_empty_ff;
      if ((type_ff == thsp_pkg::CH_DIR) || name_empty_ff ||
          (last_char_ff == thsp_pkg::CH_SLASH)) begin
         entry.kind = thsp_pkg::KIND_DIR;
      end else if (type_ff == thsp_pkg::CH_LINK) begin
         entry.kind = thsp_pkg::KIND_LINK;
      end else begin
         entry.kind = thsp_pkg::KIND_FILE;
      end
      entry.perm  = perm_ff;
      entry.uid   = uid_ff;
      entry.gid   = gid_ff;
      entry.size  = size_ff;
      entry.mtime = time_ff;
   end

endmodule

// ===== rtl/thsp_seq.sv =====
// Block sequencer: header/content/padding/end phases and result formatting.
module thsp_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          byte_in,
   input  thsp_pkg::entry_type entry,
   output logic                hdr_step,
   output logic [8:0]          pos,
   output thsp_pkg::rsp_type   rsp
);

   thsp_pkg::phase_type phase_ff, phase_in;
   logic [8:0]          pos_ff, pos_in;
   logic [36:0]         left_ff, left_in;

   assign pos = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= thsp_pkg::PH_HEADER;
         pos_ff   <= '0;
         left_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      hdr_step = 1'b0;
      rsp          = '0;
      rsp.byte_out = byte_in;
      unique case (phase_ff)
         thsp_pkg::PH_END: begin
            rsp.byte_class = thsp_pkg::CLS_END;
         end
         thsp_pkg::PH_CONTENT: begin
            rsp.byte_class = thsp_pkg::CLS_CONTENT;
            pos_in  = pos_ff + 9'd1;
            left_in = left_ff - 37'd1;
            if (left_in == '0) begin
               phase_in = (pos_in != '0) ? thsp_pkg::PH_PAD : thsp_pkg::PH_HEADER;
            end
         end
         thsp_pkg::PH_PAD: begin
            rsp.byte_class = thsp_pkg::CLS_PAD;
            pos_in = pos_ff + 9'd1;
            if (pos_in == '0) begin
               phase_in = thsp_pkg::PH_HEADER;
            end
         end
         thsp_pkg::PH_HEADER: begin
            rsp.byte_class = thsp_pkg::CLS_HEADER;
            hdr_step = step;
            pos_in   = pos_ff + 9'd1;
            if (pos_ff == thsp_pkg::POS_LAST) begin
               if (entry.zero_blk) begin
                  rsp.archive_end = 1'b1;
                  phase_in = thsp_pkg::PH_END;
               end else if (!entry.drop) begin
                  rsp.entry_valid = 1'b1;
                  rsp.entry_kind  = entry.kind;
                  rsp.perm_bits   = entry.perm;
                  rsp.owner_id    = entry.uid;
                  rsp.group_id    = entry.gid;
                  rsp.entry_size  = entry.size;
                  rsp.mod_time    = entry.mtime;
                  if ((entry.kind == thsp_pkg::KIND_FILE) && (entry.size != '0)) begin
                     left_in  = entry.size;
                     phase_in = thsp_pkg::PH_CONTENT;
                  end
               end
            end
         end
         default: begin
            rsp.byte_class = thsp_pkg::CLS_END;
         end
      endcase
   end

endmodule

// ===== rtl/thsp_checker.sv =====
// Port-level assertions for the tar stream parser, bound to the top level.
module thsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  byte_class,
   input logic [7:0]  byte_out,
   input logic        entry_valid,
   input logic [1:0]  entry_kind,
   input logic [8:0]  perm_bits,
   input logic [36:0] entry_size,
   input logic        archive_end
);

   logic end_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && archive_end) begin
         end_seen_ff <= 1'b1;
      end
   end

   // stalled result word must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(byte_class) && $stable(byte_out) &&
      $stable(entry_valid) && $stable(entry_size))
      else $error("result word changed while stalled");

   // entry report and end marker only on header words, never together
   a_report_on_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (entry_valid || archive_end) |->
      byte_class == thsp_pkg::CLS_HEADER && !(entry_valid && archive_end))
      else $error("entry/end report on non-header word");

   // once the end block is delivered, everything after is class end
   a_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && end_seen_ff |-> byte_class == thsp_pkg::CLS_END && !entry_valid)
      else $error("word after archive end not classed as end");

   // entry fields are zero without a report, kind is a legal code with one
   a_entry_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (entry_valid ?
                     (entry_kind == thsp_pkg::KIND_FILE || entry_kind == thsp_pkg::KIND_DIR ||
                      entry_kind == thsp_pkg::KIND_LINK) :
                     (entry_kind == '0 && perm_bits == '0 && entry_size == '0)))
      else $error("inconsistent entry fields");

endmodule

bind tar_header_stream_parser_unit thsp_checker u_thsp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .byte_class  (rsp_ch.byte_class),
   .byte_out    (rsp_ch.byte_out),
   .entry_valid (rsp_ch.entry_valid),
   .entry_kind  (rsp_ch.entry_kind),
   .perm_bits   (rsp_ch.perm_bits),
   .entry_size  (rsp_ch.entry_size),
   .archive_end (rsp_ch.archive_end)
);
